[design/lad_pkg.sv]
// shared constants, codes and types for the linear array deque
package lad_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOROOM = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] item_out;
        logic                     last_item;
    } t_result;

endpackage

[design/lad_ram.sv]
// single port write, single port read memory with registered read data
module lad_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/lad_ctrl.sv]
// deque sequencer: front and rear indices, memory access and result generation
module lad_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lad_pkg::FUNC_W-1:0]       i_func,
    input  logic signed [lad_pkg::DATA_W-1:0] i_data,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output lad_pkg::t_result                 o_res,
    output logic                             o_wr_en,
    output logic [lad_pkg::IDX_W-1:0]        o_wr_addr,
    output logic [lad_pkg::DATA_W-1:0]       o_wr_data,
    output logic                             o_rd_en,
    output logic [lad_pkg::IDX_W-1:0]        o_rd_addr,
    input  logic [lad_pkg::DATA_W-1:0]       i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } t_state;

    t_state                     r_state, n_state;
    logic [lad_pkg::IDX_W-1:0]  r_head, n_head;
    logic [lad_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic [lad_pkg::IDX_W-1:0]  r_ptr, n_ptr;
    logic                       r_empty, n_empty;
    logic                       w_acc;
    logic                       w_dump_last;

    assign o_ready     = (r_state == S_IDLE) && i_res_ready;
    assign w_acc       = i_valid && o_ready;
    assign w_dump_last = (r_ptr == r_tail);
    assign o_wr_data   = i_data;

    // one word at a time, so a read never meets a write to the same slot in one cycle
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_ptr       = r_ptr;
        n_empty     = r_empty;
        o_res_valid = 1'b0;
        o_res       = '{status: lad_pkg::STATUS_OK, item_out: '0, last_item: 1'b1};
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_func)
                        lad_pkg::FUNC_PUSH_FRONT, lad_pkg::FUNC_PUSH_BACK: begin
                            o_res_valid = 1'b1;
                            if (r_empty) begin
                                n_head    = '0;
                                n_tail    = '0;
                                n_empty   = 1'b0;
                                o_wr_en   = 1'b1;
                                o_wr_addr = '0;
                            end else if (i_func == lad_pkg::FUNC_PUSH_FRONT) begin
                                if (r_head == '0) begin
                                    o_res.status = lad_pkg::STATUS_NOROOM;
                                end else begin
                                    n_head    = r_head - lad_pkg::IDX_W'(1);
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = r_head - lad_pkg::IDX_W'(1);
                                end
                            end else begin
                                if (r_tail == lad_pkg::LAST_IDX) begin
                                    o_res.status = lad_pkg::STATUS_NOROOM;
                                end else begin
                                    n_tail    = r_tail + lad_pkg::IDX_W'(1);
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = r_tail + lad_pkg::IDX_W'(1);
                                end
                            end
                        end
                        lad_pkg::FUNC_POP_FRONT, lad_pkg::FUNC_POP_BACK: begin
                            if (r_empty) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lad_pkg::STATUS_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = (i_func == lad_pkg::FUNC_POP_FRONT) ? r_head
                                                                                : r_tail;
                                n_state   = S_POP;
                                if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_func == lad_pkg::FUNC_POP_FRONT) begin
                                    n_head = r_head + lad_pkg::IDX_W'(1);
                                end else begin
                                    n_tail = r_tail - lad_pkg::IDX_W'(1);
                                end
                            end
                        end
                        lad_pkg::FUNC_DUMP: begin
                            if (r_empty) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lad_pkg::STATUS_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_head;
                                n_ptr     = r_head;
                                n_state   = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                o_res_valid    = 1'b1;
                o_res.item_out = i_rd_data;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                o_res_valid     = 1'b1;
                o_res.item_out  = i_rd_data;
                o_res.last_item = w_dump_last;
                if (i_res_ready) begin
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next word while this one is taken
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_ptr + lad_pkg::IDX_W'(1);
                        n_ptr     = r_ptr + lad_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_ptr   <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ptr   <= n_ptr;
            r_empty <= n_empty;
        end
    end

`ifndef SYNTHESIS
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("front index passed rear index");

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with indices away from slot zero");

    a_dump_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_ptr >= r_head && r_ptr <= r_tail))
        else $error("dump pointer outside held words");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_empty && (i_func == lad_pkg::FUNC_POP_FRONT ||
                               i_func == lad_pkg::FUNC_POP_BACK))
        |=> (o_res_valid && r_state == S_POP))
        else $error("pop of a held word gave no result");
`endif

endmodule

[design/linear_array_deque.sv]
// top level of the linear array deque: sequencer, slot memory and output register
//
// usage
//   input channel: i_valid / o_ready carry i_func and i_data; a word is taken at a
//   clock edge where both are high. func codes: push front, push back, pop front,
//   pop back, dump all (codes five to seven are taken and give no result).
//   output channel: o_valid / i_ready carry o_status, o_item_out and o_last_item;
//   every input but codes five to seven gives one result, a dump one per held word with
//   o_last_item marking the rear word.
//   a push or refused op has its result written to the output register at the
//   acceptance edge; a pop result first passes the slot memory read register.
//   throughput: one op at a time, input waits while a pop or dump is active;
//   dump results stream one per cycle after the first memory read, as long
//   as the output register takes them. the output register can take a new
//   result in the cycle its last one drains; if the receiver stalls, the
//   register holds and the sequencer, and then o_ready, wait.
//   reset (synchronous, active low) empties the deque and clears o_valid;
//   slot contents are not cleared, only written slots are ever read.
module linear_array_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lad_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [lad_pkg::DATA_W-1:0] i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lad_pkg::STAT_W-1:0]        o_status,
    output logic signed [lad_pkg::DATA_W-1:0] o_item_out,
    output logic                              o_last_item
);

    logic                        w_res_valid;
    logic                        w_res_ready;
    lad_pkg::t_result            w_res;
    logic                        w_wr_en;
    logic [lad_pkg::IDX_W-1:0]   w_wr_addr;
    logic [lad_pkg::DATA_W-1:0]  w_wr_data;
    logic                        w_rd_en;
    logic [lad_pkg::IDX_W-1:0]   w_rd_addr;
    logic [lad_pkg::DATA_W-1:0]  w_rd_data;
    logic                        r_out_valid;
    lad_pkg::t_result            r_out;

    lad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_data      (i_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    lad_ram #(
        .DATA_W (lad_pkg::DATA_W),
        .DEPTH  (lad_pkg::DEPTH),
        .ADDR_W (lad_pkg::IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // register is free when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_item_out  = r_out.item_out;
    assign o_last_item = r_out.last_item;

endmodule
